// ===== design/sfl_pkg.sv =====
// ----------------------------------------------------------------------------
// sfl_pkg
// shared types, codes and constants of the sorted free list slot allocator
// ----------------------------------------------------------------------------
package sfl_pkg;

  localparam int SLOTS_DEF  = 256;
  localparam int COORDS_DEF = 3;

  localparam int COORD_W = 32;
  localparam int INDEX_W = 9;
  localparam int SLOT_W  = 8;
  localparam int HEAD_W  = 9;
  localparam int SCAN_W  = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef struct packed {
    logic take;
    logic ins_issue;
    logic ins_finish;
    logic res_full;
    logic res_bad;
    logic rm_front;
    logic scan_init;
    logic scan_step;
    logic copy;
    logic fix;
    logic load_out;
  } sfl_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic full;
    logic rm_bad;
    logic below;
    logic found;
    logic head_ok;
    logic head_free;
  } sfl_sts_t;

endpackage

// ===== design/slot_allocator_sorted_free_list.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_sorted_free_list
// coordinate slot store with an address-sorted free list
//
//   channel   words                                          handshake
//   in        opcode coord_x coord_y coord_z slot_index      in_valid / in_stall
//   out       status slot_used head_after                    out_valid / out_stall
//
// insert: decode, insert and done states from accept to result
// full store, bad remove and remove below the head: decode and done states
// remove above the head: decode, scan, copy, fix and done states; the scan
//   for the nearest lower free slot steps down one 32-slot word at a time
// one word in flight; a waiting result does not block the next accept
// rst synchronous active high; all slots free, head at slot zero
// ----------------------------------------------------------------------------
module slot_allocator_sorted_free_list
  import sfl_pkg::*;
#(
  parameter int SLOTS  = SLOTS_DEF,
  parameter int COORDS = COORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [COORD_W-1:0] coord_x,
  input  logic [COORD_W-1:0] coord_y,
  input  logic [COORD_W-1:0] coord_z,
  input  logic [INDEX_W-1:0] slot_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [SLOT_W-1:0]  slot_used,
  output logic [HEAD_W-1:0]  head_after
);

  sfl_cmd_t cmd;
  sfl_sts_t sts;

  sfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfl_datapath #(
    .SLOTS  (SLOTS),
    .COORDS (COORDS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .opcode     (opcode),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .slot_index (slot_index),
    .status     (status),
    .slot_used  (slot_used),
    .head_after (head_after)
  );

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    sts.head_ok)
    else $error("free head beyond slot count");

  a_head_free: assert property (@(posedge clk) disable iff (rst)
    sts.head_free)
    else $error("free head points at a used slot");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled word");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

endmodule

// ===== design/sfl_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfl_ctrl
// sequencer for insert and remove, drives datapath commands and handshakes
// ----------------------------------------------------------------------------
module sfl_ctrl
  import sfl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  sfl_sts_t sts,
  output sfl_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECODE = 7'b0000010,
    S_INS    = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_COPY   = 7'b0010000,
    S_FIX    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts.is_insert && sts.full) begin
          cmd.res_full = 1'b1;
          state_next   = S_DONE;
        end else if (sts.is_insert) begin
          cmd.ins_issue = 1'b1;
          state_next    = S_INS;
        end else if (sts.rm_bad) begin
          cmd.res_bad = 1'b1;
          state_next  = S_DONE;
        end else if (sts.below) begin
          cmd.rm_front = 1'b1;
          state_next   = S_DONE;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_INS: begin
        cmd.ins_finish = 1'b1;
        state_next     = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.found) begin
          state_next = S_COPY;
        end
      end
      S_COPY: begin
        cmd.copy   = 1'b1;
        state_next = S_FIX;
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/sfl_datapath.sv =====
// ----------------------------------------------------------------------------
// sfl_datapath
// free and link marks, link memory, coordinate memory, free slot scanner
// and result registers
// ----------------------------------------------------------------------------
module sfl_datapath
  import sfl_pkg::*;
#(
  parameter int SLOTS  = SLOTS_DEF,
  parameter int COORDS = COORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  sfl_cmd_t           cmd,
  output sfl_sts_t           sts,
  input  logic               opcode,
  input  logic [COORD_W-1:0] coord_x,
  input  logic [COORD_W-1:0] coord_y,
  input  logic [COORD_W-1:0] coord_z,
  input  logic [INDEX_W-1:0] slot_index,
  output logic [1:0]         status,
  output logic [SLOT_W-1:0]  slot_used,
  output logic [HEAD_W-1:0]  head_after
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HW    = $clog2(SLOTS + 1);
  localparam int WORDS = (SLOTS + SCAN_W - 1) / SCAN_W;
  localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FW    = WORDS * SCAN_W;
  localparam int LW    = $clog2(SCAN_W);
  localparam int CW    = COORDS * COORD_W;

  logic [CW-1:0] coord_mem [SLOTS];
  logic [HW-1:0] link_mem  [SLOTS];

  logic               op_q;
  logic [INDEX_W-1:0] idx_q;
  logic [COORD_W-1:0] coord_q [3];
  logic [HW-1:0]      head;
  logic [SLOTS-1:0]   free_vec;
  logic [SLOTS-1:0]   impl_vec;
  logic [HW-1:0]      link_rd;
  logic [SW-1:0]      p_q;
  logic [WW-1:0]      word_q;
  logic               first_q;
  status_t            res_status;
  logic [SW-1:0]      res_slot;

  logic [31:0]        idx_w;
  logic [31:0]        head_w;
  logic [SW-1:0]      is;
  logic [SW-1:0]      hs;
  logic [LW-1:0]      lo;
  logic               idx_ok;
  logic [FW-1:0]      free_pad;
  logic [SCAN_W-1:0]  scan_word;
  logic [SCAN_W-1:0]  scan_mask;
  logic [SCAN_W-1:0]  scan_hit;
  logic [LW-1:0]      enc;
  logic [31:0]        p_w;
  logic [SW-1:0]      p_comb;
  logic [SW-1:0]      rd_addr;
  logic               wr_en;
  logic [SW-1:0]      wr_addr;
  logic [HW-1:0]      wr_data;
  logic [CW-1:0]      coord_word;
  logic [31:0]        res_slot_w;

  assign idx_w    = 32'(idx_q);
  assign head_w   = 32'(head);
  assign is       = idx_w[SW-1:0];
  assign hs       = head[SW-1:0];
  assign lo       = idx_w[LW-1:0];
  assign idx_ok   = idx_w < 32'(SLOTS);
  assign free_pad = FW'(free_vec);

  assign sts.is_insert = (op_q == OP_INSERT);
  assign sts.full      = (head_w == 32'(SLOTS));
  assign sts.rm_bad    = idx_ok ? free_vec[is] : 1'b1;
  assign sts.below     = idx_w < head_w;
  assign sts.found     = |scan_hit;
  assign sts.head_ok   = head_w <= 32'(SLOTS);
  assign sts.head_free = (head_w >= 32'(SLOTS)) ? 1'b1 : free_vec[hs];

  // free slot scan, one word a cycle from the removed slot downward
  assign scan_word = free_pad[(32'(word_q) << LW) +: SCAN_W];
  assign scan_mask = first_q ? ((SCAN_W'(1) << lo) - SCAN_W'(1)) : '1;
  assign scan_hit  = scan_word & scan_mask;

  always_comb begin
    enc = '0;
    for (int i = 0; i < SCAN_W; i++) begin
      if (scan_hit[i]) begin
        enc = LW'(i);
      end
    end
  end

  assign p_w    = (32'(word_q) << LW) | 32'(enc);
  assign p_comb = p_w[SW-1:0];

  assign rd_addr = cmd.scan_step ? p_comb : hs;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = is;
    wr_data = head;
    priority if (cmd.rm_front) begin
      wr_en = 1'b1;
    end else if (cmd.copy) begin
      wr_en   = 1'b1;
      wr_data = link_rd;
    end else if (cmd.fix) begin
      wr_en   = 1'b1;
      wr_addr = p_q;
      wr_data = HW'(is);
    end else begin
      wr_en = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < COORDS; i++) begin
      coord_word[i*COORD_W +: COORD_W] = coord_q[i];
    end
  end

  always_ff @(posedge clk) begin
    link_rd <= link_mem[rd_addr];
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (cmd.ins_issue) begin
      coord_mem[hs] <= coord_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_q       <= opcode;
      idx_q      <= slot_index;
      coord_q[0] <= coord_x;
      coord_q[1] <= coord_y;
      coord_q[2] <= coord_z;
    end
    if (cmd.scan_init) begin
      word_q  <= idx_w[LW +: WW];
      first_q <= 1'b1;
    end else if (cmd.scan_step) begin
      p_q     <= p_comb;
      word_q  <= word_q - WW'(1);
      first_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      free_vec   <= '1;
      impl_vec   <= '1;
      res_status <= ST_DONE;
      res_slot   <= '0;
    end else begin
      if (cmd.res_full) begin
        res_status <= ST_FULL;
        res_slot   <= '0;
      end
      if (cmd.res_bad) begin
        res_status <= ST_BAD;
        res_slot   <= '0;
      end
      if (cmd.ins_finish) begin
        head         <= impl_vec[hs] ? head + HW'(1) : link_rd;
        free_vec[hs] <= 1'b0;
        res_status   <= ST_DONE;
        res_slot     <= hs;
      end
      if (cmd.rm_front) begin
        head         <= HW'(is);
        impl_vec[is] <= 1'b0;
        free_vec[is] <= 1'b1;
        res_status   <= ST_DONE;
        res_slot     <= is;
      end
      if (cmd.copy) begin
        impl_vec[is] <= impl_vec[p_q];
      end
      if (cmd.fix) begin
        impl_vec[p_q] <= 1'b0;
        free_vec[is]  <= 1'b1;
        res_status    <= ST_DONE;
        res_slot      <= is;
      end
    end
  end

  assign res_slot_w = 32'(res_slot);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status     <= res_status;
      slot_used  <= res_slot_w[SLOT_W-1:0];
      head_after <= head_w[HEAD_W-1:0];
    end
  end

endmodule

// ===== sim/free_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_checker
// watches both channels of the slot allocator, keeps its own copy of the
// free marks, links and head, predicts each result word and compares it
// field by field with what the block returns, in order
// ----------------------------------------------------------------------------
module free_list_checker
  import sfl_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               opcode,
  input  logic [INDEX_W-1:0] slot_index,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [1:0]         status,
  input  logic [SLOT_W-1:0]  slot_used,
  input  logic [HEAD_W-1:0]  head_after,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [HEAD_W-1:0]   head;
  } alloc_result_t;

  logic          is_free [SLOTS];
  logic          follows_next [SLOTS];
  int            link_to [SLOTS];
  int            head_slot;
  alloc_result_t results_due [$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
  end

  task automatic report_error(string msg);
    if (fail_count < 40) $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic alloc_result_t apply_request(opcode_t op, logic [INDEX_W-1:0] idx);
    alloc_result_t r;
    int            h;
    int            i;
    int            nxt;
    int            p;
    h        = head_slot;
    i        = int'(idx);
    r.status = ST_DONE;
    r.slot   = '0;
    if (op == OP_INSERT) begin
      if (h >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        nxt = follows_next[h] ? h + 1 : link_to[h];
        if (nxt > SLOTS) nxt = SLOTS;
        is_free[h] = 1'b0;
        head_slot  = nxt;
        r.slot     = SLOT_W'(h);
      end
    end else if (i >= SLOTS || is_free[i]) begin
      r.status = ST_BAD;
    end else begin
      if (i < h) begin
        follows_next[i] = 1'b0;
        link_to[i]      = h;
        head_slot       = i;
      end else begin
        // nearest lower free slot; the head bounds the search
        p = i - 1;
        while (p > h && !is_free[p]) p--;
        follows_next[i] = follows_next[p];
        link_to[i]      = link_to[p];
        follows_next[p] = 1'b0;
        link_to[p]      = i;
      end
      is_free[i] = 1'b1;
      r.slot     = SLOT_W'(i);
    end
    r.head = HEAD_W'(head_slot);
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      for (int k = 0; k < SLOTS; k++) begin
        is_free[k]      = 1'b1;
        follows_next[k] = 1'b1;
        link_to[k]      = 0;
      end
      head_slot = 0;
      results_due.delete();
    end else begin
      if (in_valid && !in_stall) begin
        results_due.push_back(apply_request(opcode_t'(opcode), slot_index));
      end
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_error("result word with nothing expected");
        end else begin
          want = results_due.pop_front();
          if (status !== want.status)
            report_error($sformatf("status got %0d expected %0d", status, want.status));
          if (slot_used !== want.slot)
            report_error($sformatf("slot_used got %0d expected %0d", slot_used, want.slot));
          if (head_after !== want.head)
            report_error($sformatf("head_after got %0d expected %0d", head_after, want.head));
        end
      end
    end
    pending_count <= results_due.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus for the sorted free list slot allocator: a directed opening over
// the corner cases, then fill and drain phases of random words, with random
// gaps on both sides, a long receiver hold-off and pauses until all results
// are back; checking is done by free_list_checker
// ----------------------------------------------------------------------------
module tb;
  import sfl_pkg::*;

  localparam int SLOTS        = SLOTS_DEF;
  localparam int RANDOM_WORDS = 1130;
  localparam int LIMIT        = 500000;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               opcode     = OP_INSERT;
  logic [COORD_W-1:0] coord_x    = '0;
  logic [COORD_W-1:0] coord_y    = '0;
  logic [COORD_W-1:0] coord_z    = '0;
  logic [INDEX_W-1:0] slot_index = '0;
  logic               out_stall  = 1'b0;
  logic               in_stall;
  logic               out_valid;
  logic [1:0]         status;
  logic [SLOT_W-1:0]  slot_used;
  logic [HEAD_W-1:0]  head_after;
  int                 fail_count;
  int                 pending_count;
  int                 cycles     = 0;
  int                 words_sent = 0;
  int                 calm_left  = 0;

  slot_allocator_sorted_free_list #(
    .SLOTS (SLOTS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .coord_z    (coord_z),
    .slot_index (slot_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .slot_used  (slot_used),
    .head_after (head_after)
  );

  free_list_checker #(
    .SLOTS (SLOTS)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .slot_index    (slot_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .slot_used     (slot_used),
    .head_after    (head_after),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("** slot_allocator_sorted_free_list: FAILED **");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [INDEX_W-1:0] pick_index();
    if ($urandom_range(0, 99) < 8) return INDEX_W'($urandom_range(SLOTS, 511));
    return INDEX_W'($urandom_range(0, SLOTS - 1));
  endfunction

  task automatic send_word(opcode_t op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic [COORD_W-1:0] z, logic [INDEX_W-1:0] idx);
    int gap;
    in_valid   <= 1'b1;
    opcode     <= op;
    coord_x    <= x;
    coord_y    <= y;
    coord_z    <= z;
    slot_index <= idx;
    do @(posedge clk); while (in_stall);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic insert_word(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COORD_W-1:0] z);
    send_word(OP_INSERT, x, y, z, pick_index());
  endtask

  task automatic remove_word(logic [INDEX_W-1:0] idx);
    send_word(OP_REMOVE, $urandom, $urandom, $urandom, idx);
  endtask

  task automatic wait_all_returned();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // receiver: random stall pattern, with one long hold-off early on
  initial begin
    int r;
    int len;
    bit held;
    held = 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (!held && words_sent >= 60) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 40) begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 20);
      end else if (r < 90) begin
        out_stall <= 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        len = $urandom_range(10, 40);
      end
      repeat (len) @(posedge clk);
    end
  end

  initial begin
    int      remaining;
    int      phase;
    int      len;
    int      ins_pct;
    opcode_t op;
    wait (!rst);
    @(posedge clk);

    // directed opening
    insert_word('0, '0, '0);
    insert_word('1, '1, '1);
    insert_word('1, '0, 32'hAAAA_5555);
    insert_word(32'h5555_AAAA, 32'h8000_0001, '1);
    insert_word($urandom, $urandom, $urandom);
    remove_word(INDEX_W'(0));             // below the head
    remove_word(INDEX_W'(0));             // the head itself, already free
    remove_word(INDEX_W'(SLOTS));         // just out of range
    remove_word('1);                      // top of the index field
    remove_word(INDEX_W'(5));             // free slot above the head
    remove_word(INDEX_W'(3));             // above the head, scan down
    remove_word(INDEX_W'(1));             // above the head, next to it
    insert_word($urandom, $urandom, $urandom);
    insert_word($urandom, $urandom, $urandom);
    insert_word($urandom, $urandom, $urandom);
    insert_word($urandom, $urandom, $urandom);
    remove_word(INDEX_W'(SLOTS - 1));     // last slot, never used
    remove_word(INDEX_W'(4));
    remove_word(INDEX_W'(2));
    insert_word('1, '0, '1);
    insert_word('0, '1, '0);
    wait_all_returned();

    // random: alternating fill and drain phases, the first one fills the store
    remaining = RANDOM_WORDS;
    phase     = 0;
    while (remaining > 0) begin
      len = (phase == 0) ? 320 : $urandom_range(60, 250);
      if (len > remaining) len = remaining;
      if (phase == 0) ins_pct = 95;
      else if (phase % 2 == 0) ins_pct = 85;
      else ins_pct = 25;
      for (int n = 0; n < len; n++) begin
        op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
        send_word(op, $urandom, $urandom, $urandom, pick_index());
      end
      remaining -= len;
      phase++;
      if (phase == 2) wait_all_returned();
    end

    wait_all_returned();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("** slot_allocator_sorted_free_list: PASSED **");
    end else begin
      $display("** slot_allocator_sorted_free_list: FAILED **");
    end
    $finish;
  end

endmodule
